// File: rtl/atd_pkg.sv
// Shared types, constants and step functions for the affine decompose pipeline.
// No dependencies.
package atd_pkg;

  localparam int SQRT_LAT = 32;  // one root bit per stage, 64-bit radicand
  localparam int DIV_LAT  = 31;  // one quotient bit per stage
  localparam logic [31:0] QONE = 32'h4000_0000;  // 1.0 in Q2.30

  typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} branch_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } sqrt_st_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] lo;
    logic [32:0] den;
    logic        ovf;
    logic        dz;
  } div_st_t;

  // one digit of the bitwise integer square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int k);
    logic [63:0] b;
    logic [63:0] t;
    sqrt_st_t    o;
    b = 64'd1 << (2 * k);
    t = s.res + b;
    if (s.x >= t) begin
      o.x   = s.x - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.x   = s.x;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic div_st_t div_init(logic [61:0] num, logic [32:0] den);
    div_st_t o;
    o.rem = {2'b00, num[61:31]};
    o.lo  = num[30:0];
    o.den = den;
    o.ovf = ({2'b00, num[61:31]} >= den);
    o.dz  = (den == 33'd0);
    return o;
  endfunction

  // one restoring-division step: quotient bits shift into lo
  function automatic div_st_t div_step(div_st_t s);
    logic [33:0] t;
    div_st_t     o;
    o = s;
    t = {s.rem, s.lo[30]};
    if (t >= {1'b0, s.den}) begin
      o.rem = 33'(t - {1'b0, s.den});
      o.lo  = {s.lo[29:0], 1'b1};
    end else begin
      o.rem = t[32:0];
      o.lo  = {s.lo[29:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: rtl/atd_isqrt.sv
// Pipelined floor square root, 64-bit radicand to 32-bit root.
// Uses atd_pkg (sqrt_step, SQRT_LAT).
module atd_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  atd_pkg::sqrt_st_t st [atd_pkg::SQRT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= atd_pkg::sqrt_step('{x: rad, res: 64'd0}, atd_pkg::SQRT_LAT - 1);
      for (int i = 1; i < atd_pkg::SQRT_LAT; i++) begin
        st[i] <= atd_pkg::sqrt_step(st[i-1], atd_pkg::SQRT_LAT - 1 - i);
      end
    end
  end

  assign root = st[atd_pkg::SQRT_LAT-1].res[31:0];

endmodule

// File: rtl/atd_div.sv
// Pipelined unsigned divider: 62-bit dividend, 33-bit divisor, 31-bit quotient.
// Uses atd_pkg (div_init, div_step, DIV_LAT). Zero divisor gives zero.
module atd_div (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] num,
  input  logic [32:0] den,
  output logic [30:0] quo,
  output logic        ovf
);

  atd_pkg::div_st_t st [atd_pkg::DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= atd_pkg::div_step(atd_pkg::div_init(num, den));
      for (int i = 1; i < atd_pkg::DIV_LAT; i++) begin
        st[i] <= atd_pkg::div_step(st[i-1]);
      end
    end
  end

  assign quo = st[atd_pkg::DIV_LAT-1].dz ? 31'd0 : st[atd_pkg::DIV_LAT-1].lo;
  assign ovf = st[atd_pkg::DIV_LAT-1].ovf & ~st[atd_pkg::DIV_LAT-1].dz;

endmodule

// File: rtl/affine_transform_decompose.sv
// Top level: affine matrix to position, scale and rotation quaternion.
// Uses atd_pkg, atd_isqrt, atd_div.
//
//  channel | handshake            | beat
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | r0c0..r2c3, signed Q16.16
//  out     | out_valid / out_ready| pos_*, scale_*, quat_* (Q2.30), zero_scale
//
// One beat enters per cycle while the output is not stalled. Stages in order:
//   magnitude, square, sum, row length root, row divide, trace, branch,
//   branch root, quaternion divide, out.
// The latency is set by the two bit-per-stage roots and dividers.
// rst clears only the valid pipe; data registers are not reset.
// The whole pipe holds when an output beat waits; in_ready = !out_valid | out_ready.
module affine_transform_decompose (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] r0c0, r0c1, r0c2, r0c3,
  input  logic signed [31:0] r1c0, r1c1, r1c2, r1c3,
  input  logic signed [31:0] r2c0, r2c1, r2c2, r2c3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x, pos_y, pos_z,
  output logic        [31:0] scale_x, scale_y, scale_z,
  output logic signed [31:0] quat_x, quat_y, quat_z, quat_w,
  output logic               zero_scale
);

  localparam int LAT = 6 + 2 * atd_pkg::SQRT_LAT + 2 * atd_pkg::DIV_LAT;

  // front data: element magnitudes and signs, translation
  typedef struct packed {
    logic [8:0]       neg;
    logic [8:0][31:0] mag;
    logic [2:0][31:0] pos;
  } front_t;

  // carried through the row divides
  typedef struct packed {
    logic [8:0]       neg;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] sc;
  } rowd_t;

  // carried through the branch root
  typedef struct packed {
    logic [2:0]        nneg;
    logic [2:0][31:0]  nmag;
    atd_pkg::branch_t  br;
    logic              zero;
    logic [2:0][31:0]  pos;
    logic [2:0][31:0]  sc;
  } qr_t;

  // carried through the quaternion divides
  typedef struct packed {
    logic [2:0]        nneg;
    atd_pkg::branch_t  br;
    logic              zero;
    logic [2:0][31:0]  pos;
    logic [2:0][31:0]  sc;
    logic [30:0]       half;
  } qd_t;

  logic             en;
  logic [LAT-1:0]   vld;

  assign en        = ~out_valid | out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // ---- front: magnitudes, squares, row sums ----
  logic signed [31:0] m_in [9];
  assign m_in = '{r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2};

  front_t           f1, f2, f3;
  logic [8:0][63:0] sq2;
  logic [2:0][63:0] sum3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        f1.neg[i] <= m_in[i][31];
        f1.mag[i] <= m_in[i][31] ? 32'(-m_in[i]) : m_in[i];
      end
      f1.pos <= {r2c3, r1c3, r0c3};
      f2 <= f1;
      for (int i = 0; i < 9; i++) begin
        sq2[i] <= 64'(f1.mag[i]) * 64'(f1.mag[i]);
      end
      f3 <= f2;
      for (int i = 0; i < 3; i++) begin
        sum3[i] <= sq2[3*i] + sq2[3*i+1] + sq2[3*i+2];
      end
    end
  end

  // ---- row lengths ----
  logic [2:0][31:0] sc_root;
  front_t           dly_a [atd_pkg::SQRT_LAT];

  for (genvar g = 0; g < 3; g++) begin : g_scale
    atd_isqrt u_sqrt (.clk(clk), .en(en), .rad(sum3[g]), .root(sc_root[g]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_a[0] <= f3;
      for (int i = 1; i < atd_pkg::SQRT_LAT; i++) dly_a[i] <= dly_a[i-1];
    end
  end

  front_t fa;
  assign fa = dly_a[atd_pkg::SQRT_LAT-1];

  // ---- normalized rotation elements ----
  logic [8:0][30:0] rq;
  rowd_t            dly_b [atd_pkg::DIV_LAT];

  for (genvar g = 0; g < 9; g++) begin : g_rdiv
    atd_div u_div (
      .clk(clk), .en(en),
      .num({fa.mag[g], 30'd0}),
      .den({1'b0, sc_root[g/3]}),
      .quo(rq[g]), .ovf()
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_b[0] <= '{neg: fa.neg, pos: fa.pos, sc: sc_root};
      for (int i = 1; i < atd_pkg::DIV_LAT; i++) dly_b[i] <= dly_b[i-1];
    end
  end

  rowd_t fb;
  assign fb = dly_b[atd_pkg::DIV_LAT-1];

  // ---- P1: signed elements and trace ----
  logic signed [31:0] r1 [9];
  logic signed [33:0] trace1;
  logic [2:0][31:0]   pos1, sc1;
  logic               zero1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        r1[i] <= fb.neg[i] ? 32'(-{1'b0, rq[i]}) : {1'b0, rq[i]};
      end
      trace1 <= 34'({1'b0, rq[0]}) * (fb.neg[0] ? -34'sd1 : 34'sd1)
              + 34'({1'b0, rq[4]}) * (fb.neg[4] ? -34'sd1 : 34'sd1)
              + 34'({1'b0, rq[8]}) * (fb.neg[8] ? -34'sd1 : 34'sd1);
      pos1  <= fb.pos;
      sc1   <= fb.sc;
      zero1 <= (fb.sc[0] == 32'd0) | (fb.sc[1] == 32'd0) | (fb.sc[2] == 32'd0);
    end
  end

  // ---- P2: branch choice, radicand, numerators ----
  localparam logic signed [33:0] Q34 = 34'(atd_pkg::QONE);

  atd_pkg::branch_t   br_c;
  logic signed [33:0] t_c;
  logic signed [33:0] d_c [3];
  logic signed [33:0] e [9];

  always_comb begin
    for (int i = 0; i < 9; i++) e[i] = 34'(r1[i]);
    if (trace1 > 34'sd0) begin
      br_c   = atd_pkg::BR_TRACE;
      t_c    = trace1 + Q34;
      d_c[0] = e[5] - e[7];
      d_c[1] = e[6] - e[2];
      d_c[2] = e[1] - e[3];
    end else if (r1[0] > r1[4] && r1[0] > r1[8]) begin
      br_c   = atd_pkg::BR_X;
      t_c    = Q34 + e[0] - e[4] - e[8];
      d_c[0] = e[3] + e[1];
      d_c[1] = e[6] + e[2];
      d_c[2] = e[5] - e[7];
    end else if (r1[4] > r1[8]) begin
      br_c   = atd_pkg::BR_Y;
      t_c    = Q34 + e[4] - e[0] - e[8];
      d_c[0] = e[3] + e[1];
      d_c[1] = e[7] + e[5];
      d_c[2] = e[6] - e[2];
    end else begin
      br_c   = atd_pkg::BR_Z;
      t_c    = Q34 + e[8] - e[0] - e[4];
      d_c[0] = e[6] + e[2];
      d_c[1] = e[7] + e[5];
      d_c[2] = e[1] - e[3];
    end
  end

  qr_t         p2;
  logic [63:0] rad2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p2.nneg[k] <= d_c[k][33];
        p2.nmag[k] <= d_c[k][33] ? 32'(-d_c[k]) : d_c[k][31:0];
      end
      p2.br   <= br_c;
      p2.zero <= zero1;
      p2.pos  <= pos1;
      p2.sc   <= sc1;
      rad2    <= (t_c > 34'sd0) ? (64'(t_c[32:0]) << 30) : 64'd0;
    end
  end

  // ---- branch root ----
  logic [31:0] s_root;
  qr_t         dly_c [atd_pkg::SQRT_LAT];

  atd_isqrt u_qsqrt (.clk(clk), .en(en), .rad(rad2), .root(s_root));

  always_ff @(posedge clk) begin
    if (en) begin
      dly_c[0] <= p2;
      for (int i = 1; i < atd_pkg::SQRT_LAT; i++) dly_c[i] <= dly_c[i-1];
    end
  end

  qr_t fc;
  assign fc = dly_c[atd_pkg::SQRT_LAT-1];

  // ---- quaternion divides by 2s ----
  logic [2:0][30:0] qq;
  logic [2:0]       qovf;
  qd_t              dly_d [atd_pkg::DIV_LAT];

  for (genvar g = 0; g < 3; g++) begin : g_qdiv
    atd_div u_div (
      .clk(clk), .en(en),
      .num({fc.nmag[g], 30'd0}),
      .den({s_root, 1'b0}),
      .quo(qq[g]), .ovf(qovf[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_d[0] <= '{nneg: fc.nneg, br: fc.br, zero: fc.zero, pos: fc.pos, sc: fc.sc,
                    half: s_root[31:1]};
      for (int i = 1; i < atd_pkg::DIV_LAT; i++) dly_d[i] <= dly_d[i-1];
    end
  end

  qd_t fd;
  assign fd = dly_d[atd_pkg::DIV_LAT-1];

  // ---- clamp, sign, place ----
  logic [30:0]       mq [3];
  logic signed [31:0] v [3];
  logic signed [31:0] hv;
  logic signed [31:0] qx_c, qy_c, qz_c, qw_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mq[k] = (qovf[k] || qq[k] > atd_pkg::QONE[30:0]) ? atd_pkg::QONE[30:0] : qq[k];
      v[k]  = fd.nneg[k] ? 32'(-{1'b0, mq[k]}) : {1'b0, mq[k]};
    end
    hv = {1'b0, fd.half};
    case (fd.br)
      atd_pkg::BR_TRACE: begin qx_c = v[0]; qy_c = v[1]; qz_c = v[2]; qw_c = hv; end
      atd_pkg::BR_X:     begin qx_c = hv; qy_c = v[0]; qz_c = v[1]; qw_c = v[2]; end
      atd_pkg::BR_Y:     begin qx_c = v[0]; qy_c = hv; qz_c = v[1]; qw_c = v[2]; end
      default:           begin qx_c = v[0]; qy_c = v[1]; qz_c = hv; qw_c = v[2]; end
    endcase
    if (fd.zero) begin
      qx_c = '0;
      qy_c = '0;
      qz_c = '0;
      qw_c = atd_pkg::QONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x      <= fd.pos[0];
      pos_y      <= fd.pos[1];
      pos_z      <= fd.pos[2];
      scale_x    <= fd.sc[0];
      scale_y    <= fd.sc[1];
      scale_z    <= fd.sc[2];
      quat_x     <= qx_c;
      quat_y     <= qy_c;
      quat_z     <= qz_c;
      quat_w     <= qw_c;
      zero_scale <= fd.zero;
    end
  end

endmodule

// File: rtl/atd_check.sv
// Port-level checker for affine_transform_decompose, attached by bind.
// Depends on the top level's ports only.
module atd_check (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pos_x,
  input logic [31:0] scale_x, scale_y, scale_z,
  input logic [31:0] quat_x, quat_y, quat_z, quat_w,
  input logic        zero_scale
);

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(quat_w))
    else $error("stalled output beat changed");

  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_scale |-> quat_x == 32'd0 && quat_y == 32'd0 &&
      quat_z == 32'd0 && quat_w == 32'h4000_0000)
    else $error("zero scale without identity rotation");

  a_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_scale |-> scale_x != 32'd0 && scale_y != 32'd0 && scale_z != 32'd0)
    else $error("zero scale flag missing");

  a_rst: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind affine_transform_decompose atd_check u_atd_check (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .pos_x(pos_x), .scale_x(scale_x), .scale_y(scale_y),
  .scale_z(scale_z), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
  .quat_w(quat_w), .zero_scale(zero_scale)
);

// File: verif/tb.sv
// Testbench for affine_transform_decompose: matrix beats in, TRS and quaternion out.
// Depends on atd_pkg (QONE) and the RTL top level; self-checking, no files read.
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] r0c0 = '0, r0c1 = '0, r0c2 = '0, r0c3 = '0;
  logic signed [31:0] r1c0 = '0, r1c1 = '0, r1c2 = '0, r1c3 = '0;
  logic signed [31:0] r2c0 = '0, r2c1 = '0, r2c2 = '0, r2c3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [31:0] scale_x, scale_y, scale_z;
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
  logic zero_scale;

  // one expected output beat
  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] scl [3];
    logic [31:0] quat [4];
    logic        zs;
  } trs_t;

  trs_t trs_q [$];
  int   errors = 0;

  affine_transform_decompose dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor: 64-bit integer arithmetic, same truncations as the block
  // ---------------------------------------------------------------------
  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // truncating signed divide by a magnitude; zero divisor yields zero
  function automatic longint tdiv(longint num, longint unsigned den);
    longint unsigned mg, qt;
    if (den == 0) return 0;
    mg = (num < 0) ? -num : num;
    qt = mg / den;
    return (num < 0) ? -longint'(qt) : longint'(qt);
  endfunction

  function automatic longint unsigned qroot(longint t);
    if (t <= 0) return 0;
    return root64(64'(t) << 30);
  endfunction

  function automatic longint clampq(longint v);
    longint one;
    one = longint'(atd_pkg::QONE);
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic trs_t decompose(logic signed [31:0] m [3][4]);
    trs_t e;
    longint mm [3][3];
    longint rr [3][3];
    longint unsigned sc [3];
    longint unsigned s, den, sum, a;
    longint q [4];
    longint one, tr;
    bit zero;
    one = longint'(atd_pkg::QONE);
    zero = 0;
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        mm[i][j] = m[i][j];
        a = (mm[i][j] < 0) ? -mm[i][j] : mm[i][j];
        sum += a * a;
      end
      sc[i] = root64(sum);
      if (sc[i] > 64'hFFFF_FFFF) sc[i] = 64'hFFFF_FFFF;
      if (sc[i] == 0) zero = 1;
      e.pos[i] = m[i][3];
      e.scl[i] = sc[i][31:0];
    end
    if (zero) begin
      q[0] = 0; q[1] = 0; q[2] = 0; q[3] = one;
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          rr[i][j] = tdiv(mm[i][j] * one, sc[i]);
      tr = rr[0][0] + rr[1][1] + rr[2][2];
      if (tr > 0) begin
        s = qroot(tr + one); den = 2 * s;
        q[0] = tdiv((rr[1][2] - rr[2][1]) * one, den);
        q[1] = tdiv((rr[2][0] - rr[0][2]) * one, den);
        q[2] = tdiv((rr[0][1] - rr[1][0]) * one, den);
        q[3] = longint'(s >> 1);
      end else if (rr[0][0] > rr[1][1] && rr[0][0] > rr[2][2]) begin
        s = qroot(one + rr[0][0] - rr[1][1] - rr[2][2]); den = 2 * s;
        q[0] = longint'(s >> 1);
        q[1] = tdiv((rr[1][0] + rr[0][1]) * one, den);
        q[2] = tdiv((rr[2][0] + rr[0][2]) * one, den);
        q[3] = tdiv((rr[1][2] - rr[2][1]) * one, den);
      end else if (rr[1][1] > rr[2][2]) begin
        s = qroot(one + rr[1][1] - rr[0][0] - rr[2][2]); den = 2 * s;
        q[0] = tdiv((rr[1][0] + rr[0][1]) * one, den);
        q[1] = longint'(s >> 1);
        q[2] = tdiv((rr[2][1] + rr[1][2]) * one, den);
        q[3] = tdiv((rr[2][0] - rr[0][2]) * one, den);
      end else begin
        s = qroot(one + rr[2][2] - rr[0][0] - rr[1][1]); den = 2 * s;
        q[0] = tdiv((rr[2][0] + rr[0][2]) * one, den);
        q[1] = tdiv((rr[2][1] + rr[1][2]) * one, den);
        q[2] = longint'(s >> 1);
        q[3] = tdiv((rr[0][1] - rr[1][0]) * one, den);
      end
    end
    for (int k = 0; k < 4; k++) e.quat[k] = 32'(clampq(q[k]));
    e.zs = zero;
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // Sender and gap shaping
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // no idling at all during some stretches
  bit burst_mode = 1'b0;

  // valid drops only for a gap, so back-to-back beats keep it high
  task automatic send_matrix(logic signed [31:0] m [3][4]);
    int g;
    g = burst_mode ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    trs_q.push_back(decompose(m));
    in_valid <= 1'b1;
    r0c0 <= m[0][0]; r0c1 <= m[0][1]; r0c2 <= m[0][2]; r0c3 <= m[0][3];
    r1c0 <= m[1][0]; r1c1 <= m[1][1]; r1c2 <= m[1][2]; r1c3 <= m[1][3];
    r2c0 <= m[2][0]; r2c1 <= m[2][1]; r2c2 <= m[2][2]; r2c3 <= m[2][3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure, compare against oldest expectation
  // ---------------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  int stall = 0;
  always @(posedge clk) begin
    trs_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (trs_q.size() == 0) begin
          report("output beat with nothing expected", 32'd0, 32'd0);
        end else begin
          e = trs_q.pop_front();
          if (pos_x !== e.pos[0]) report("pos_x", pos_x, e.pos[0]);
          if (pos_y !== e.pos[1]) report("pos_y", pos_y, e.pos[1]);
          if (pos_z !== e.pos[2]) report("pos_z", pos_z, e.pos[2]);
          if (scale_x !== e.scl[0]) report("scale_x", scale_x, e.scl[0]);
          if (scale_y !== e.scl[1]) report("scale_y", scale_y, e.scl[1]);
          if (scale_z !== e.scl[2]) report("scale_z", scale_z, e.scl[2]);
          if (quat_x !== e.quat[0]) report("quat_x", quat_x, e.quat[0]);
          if (quat_y !== e.quat[1]) report("quat_y", quat_y, e.quat[1]);
          if (quat_z !== e.quat[2]) report("quat_z", quat_z, e.quat[2]);
          if (quat_w !== e.quat[3]) report("quat_w", quat_w, e.quat[3]);
          if (zero_scale !== e.zs) report("zero_scale", 32'(zero_scale), 32'(e.zs));
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
        stall = gap_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Matrix builders
  // ---------------------------------------------------------------------
  localparam logic signed [31:0] ONE16 = 32'sh0001_0000;

  function automatic void set_diag(ref logic signed [31:0] m [3][4],
                                   input logic signed [31:0] a, b, c);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++) m[i][j] = 0;
    m[0][0] = a; m[1][1] = b; m[2][2] = c;
  endfunction

  function automatic logic signed [31:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0001_FFFF;
      2: return 0;
      3: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      default: return $signed($urandom) >>> $urandom_range(0, 24);
    endcase
  endfunction

  // scaled rotation by a quarter/half turn permutation, mostly well formed
  function automatic void rnd_rot(ref logic signed [31:0] m [3][4]);
    int perm [3];
    int k;
    logic signed [31:0] sc;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      int j;
      j = $urandom_range(0, i);
      k = perm[i]; perm[i] = perm[j]; perm[j] = k;
    end
    for (int i = 0; i < 3; i++) begin
      sc = $urandom_range(1, 32'h0008_0000);
      for (int j = 0; j < 3; j++)
        m[i][j] = (j == perm[i]) ? ($urandom_range(0, 1) ? sc : -sc)
                                 : $signed($urandom_range(0, 64)) - 32;
      m[i][3] = $urandom;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    logic signed [31:0] m [3][4];
    // identity, with translation extremes
    set_diag(m, ONE16, ONE16, ONE16);
    m[0][3] = 32'sh7FFF_FFFF; m[1][3] = 32'sh8000_0000; m[2][3] = -1;
    send_matrix(m);
    // each largest-diagonal branch: half turns about x, y, z
    set_diag(m, ONE16, -ONE16, -ONE16); send_matrix(m);
    set_diag(m, -ONE16, ONE16, -ONE16); send_matrix(m);
    set_diag(m, -ONE16, -ONE16, ONE16); send_matrix(m);
    // zero row in each position
    set_diag(m, 0, ONE16, ONE16); send_matrix(m);
    set_diag(m, ONE16, 0, ONE16); send_matrix(m);
    set_diag(m, ONE16, ONE16, 0); send_matrix(m);
    set_diag(m, 0, 0, 0); send_matrix(m);
    // full-scale elements: largest row length
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++) m[i][j] = 32'sh8000_0000;
    send_matrix(m);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++) m[i][j] = 32'sh7FFF_FFFF;
    send_matrix(m);
    // tiny scales, mirrored axes
    set_diag(m, 1, -1, 1); send_matrix(m);
    set_diag(m, -1, -1, -1); send_matrix(m);
    // sheared, non-orthogonal
    set_diag(m, ONE16, ONE16, ONE16);
    m[0][1] = ONE16; m[1][2] = -ONE16; m[2][0] = ONE16 >>> 1;
    send_matrix(m);
    // quarter turn about z
    set_diag(m, 0, 0, ONE16); m[0][1] = ONE16; m[1][0] = -ONE16; send_matrix(m);
  endtask

  task automatic test_random(int n);
    logic signed [31:0] m [3][4];
    int zr;
    for (int t = 0; t < n; t++) begin
      if (t % 250 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 6) begin
        rnd_rot(m);
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 4; j++) m[i][j] = rnd_elem();
        if ($urandom_range(0, 9) == 0) begin
          zr = $urandom_range(0, 2);
          for (int j = 0; j < 3; j++) m[zr][j] = 0;
        end
      end
      send_matrix(m);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int wait_cnt;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(2000);
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (trs_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && trs_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
